/* hdl/scm_pkg.sv */
package scm_pkg;

   // Payload widths of the two item channels.
   localparam int ReqDataW = 56;
   localparam int RspDataW = 32;

   // Configuration register indexes.
   localparam logic [2:0] CsrCapLow    = 3'd0;
   localparam logic [2:0] CsrCapHigh   = 3'd1;
   localparam logic [2:0] CsrBoostDrop = 3'd2;
   localparam logic [2:0] CsrKnee      = 3'd3;
   localparam logic [2:0] CsrLowCur    = 3'd4;
   localparam logic [2:0] CsrPersist   = 3'd5;
   localparam logic [2:0] CsrBoot      = 3'd6;

   // Detector zones.
   localparam logic [1:0] ZoneLow  = 2'd0;
   localparam logic [1:0] ZoneMid  = 2'd1;
   localparam logic [1:0] ZoneHigh = 2'd2;

   // Supply source codes.
   localparam logic [1:0] SrcOff = 2'd0;
   localparam logic [1:0] SrcCap = 2'd1;
   localparam logic [1:0] SrcBat = 2'd2;

   localparam logic [13:0] MaxCurrentMa = 14'd10000;

   // The power/voltage quotient is 28 bits wide, one bit per divider step.
   localparam int DivSteps = 28;

   typedef struct packed {
      logic [15:0] cap_low_mv;
      logic [15:0] cap_high_mv;
      logic [15:0] boost_drop_mv;
      logic [15:0] knee_voltage_mv;
      logic [13:0] low_current_ma;
      logic [7:0]  persist_count;
      logic [15:0] boot_voltage_mv;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic clamp;
      logic dac_mul;
      logic dac_fix;
      logic out_load;
   } cmd_type;

endpackage

/* hdl/supercap_charge_manager.sv */
// Supercapacitor charge manager.
// One req_ item is one control tick: capacitor voltage, battery input voltage,
// charge power setpoint and supply mode. For every accepted item the block
// returns exactly one rsp_ item with the DAC code, the charge current in mA,
// the capacitor level zone, the boost enable and the selected supply source.
// Configuration registers are written through the csr_ channel, which is
// always ready; they should be written only while no item is in flight.
// Timing: an item is accepted only while the controller is idle. The result
// passes the bit-serial restoring divider that forms power over voltage, the
// current limits, the reciprocal multiply and correction that make the DAC
// code, and the load of the output register, in that order. The next item
// can be accepted in the cycle after the result is loaded, so the block takes
// no new item before it is through with the last one.
// The output register decouples the sides: a new item is accepted while the
// previous result still waits; if the receiver stalls longer, the finished
// result waits inside the block until the output register frees up.
// Reset (synchronous, active high) restores the register defaults, sets both
// detectors to the mid zone with zero counts, clears the boot latch and turns
// all supply outputs off.
module supercap_charge_manager import scm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // [15:0] cap_voltage_mv, [31:16] input_voltage_mv, [49:32] charge_power_mw,
   // [50] supply_mode, [55:51] zero
   input  logic [ReqDataW-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [11:0] dac_code, [25:12] charge_current_ma, [27:26] cap_level,
   // [28] boost_enable, [30:29] source_select, [31] zero
   output logic [RspDataW-1:0] rsp_tdata,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data
);

   cfg_type cfg_ff;
   cmd_type cmd;

   // The register file never stalls a write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cap_low_mv      <= 16'd12000;
         cfg_ff.cap_high_mv     <= 16'd23000;
         cfg_ff.boost_drop_mv   <= 16'd1000;
         cfg_ff.knee_voltage_mv <= 16'd20000;
         cfg_ff.low_current_ma  <= 14'd2000;
         cfg_ff.persist_count   <= 8'd50;
         cfg_ff.boot_voltage_mv <= 16'd15000;
      end else if (csr_valid) begin
         // Bits beyond a register's width are dropped; unused indexes are ignored.
         case (csr_index)
            CsrCapLow:    cfg_ff.cap_low_mv      <= csr_data;
            CsrCapHigh:   cfg_ff.cap_high_mv     <= csr_data;
            CsrBoostDrop: cfg_ff.boost_drop_mv   <= csr_data;
            CsrKnee:      cfg_ff.knee_voltage_mv <= csr_data;
            CsrLowCur:    cfg_ff.low_current_ma  <= csr_data[13:0];
            CsrPersist:   cfg_ff.persist_count   <= csr_data[7:0];
            CsrBoot:      cfg_ff.boot_voltage_mv <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // The controller sequences one item at a time through the datapath.
   scm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // The datapath holds the detector state, the divider and the DAC scaling.
   scm_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

   // A full capacitor must never be given charge current.
   a_full_no_current: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[27:26] == ZoneHigh)) |-> (rsp_tdata[25:12] == 14'd0))
      else $error("charge current delivered while capacitor level is full");

   // The current limit and the DAC scaling keep both within range.
   a_current_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[25:12] <= MaxCurrentMa) && (rsp_tdata[11:0] <= 12'd2482)))
      else $error("charge current or DAC code out of range");

   // A result cannot appear the cycle after its item is accepted.
   a_no_fast_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("result appeared too early after accept");

   // No item is accepted while the datapath is busy on the previous one.
   a_busy_blocks_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while previous item still in work");

endmodule

/* hdl/scm_ctrl.sv */
module scm_ctrl import scm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StDiv   = 3'd1;
   localparam logic [2:0] StClamp = 3'd2;
   localparam logic [2:0] StMul   = 3'd3;
   localparam logic [2:0] StFix   = 3'd4;
   localparam logic [2:0] StOut   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = StDiv;
            end
         end
         StDiv: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 5'd1;
            if (step_ff == 5'(DivSteps - 1)) begin
               state_in = StClamp;
            end
         end
         StClamp: begin
            cmd.clamp = 1'b1;
            state_in  = StMul;
         end
         StMul: begin
            cmd.dac_mul = 1'b1;
            state_in    = StFix;
         end
         StFix: begin
            cmd.dac_fix = 1'b1;
            state_in    = StOut;
         end
         StOut: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/scm_dpath.sv */
module scm_dpath import scm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  cmd_type             cmd,
   input  logic [ReqDataW-1:0] req_tdata,
   output logic [RspDataW-1:0] rsp_tdata
);

   typedef struct packed {
      logic [7:0] count;
      logic [1:0] zone;
   } det_type;

   // floor(2^34 / 4125); x*4096/16500 == x*1024/4125.
   localparam logic [21:0] DacRecip = 22'((64'd1 << 34) / 64'd4125);
   localparam logic [12:0] DacDiv   = 13'd4125;

   function automatic det_type det_next(det_type cur, logic is_low, logic is_high,
                                        logic [7:0] persist);
      det_type    nxt;
      logic [7:0] cnt_inc;
      cnt_inc = cur.count + 8'd1;
      nxt     = cur;
      if (is_low || is_high) begin
         if (cnt_inc >= persist) begin
            nxt.count = '0;
            nxt.zone  = is_low ? ZoneLow : ZoneHigh;
         end else begin
            nxt.count = cnt_inc;
         end
      end else begin
         nxt.count = '0;
         nxt.zone  = ZoneMid;
      end
      return nxt;
   endfunction

   logic [15:0] vcap, vin;
   logic [17:0] pwr;
   logic        mode;

   assign vcap = req_tdata[15:0];
   assign vin  = req_tdata[31:16];
   assign pwr  = req_tdata[49:32];
   assign mode = req_tdata[50];

   det_type     level_ff, level_in;
   det_type     charge_ff, charge_in;
   logic        booted_ff, booted_in;
   logic [1:0]  source_ff, source_in;

   logic [15:0] vcap_ff;
   logic [16:0] rem_ff, rem_in;
   logic [27:0] quo_ff, quo_in;
   logic [13:0] cur_ff, cur_in;
   logic [35:0] prod1_ff;
   logic [11:0] q0_ff;
   logic [23:0] prod2_ff;
   logic [RspDataW-1:0] rsp_ff;

   logic        lvl_low, lvl_high, chg_low;
   logic signed [16:0] thr, vcap_s;
   logic [27:0] dividend;
   logic [16:0] rem_sh, rem_diff;
   logic [27:0] q_sat, c1;
   logic [13:0] c2;
   logic [11:0] q0;
   logic [23:0] rem_dac;
   logic [11:0] dac;

   // Detector and source updates for the accepted item.
   always_comb begin
      lvl_low  = vcap < cfg.cap_low_mv;
      lvl_high = !lvl_low && (vcap >= cfg.cap_high_mv);
      thr      = signed'({1'b0, vin}) - signed'({1'b0, cfg.boost_drop_mv});
      vcap_s   = signed'({1'b0, vcap});
      chg_low  = vcap_s < thr;
      level_in  = det_next(level_ff, lvl_low, lvl_high, cfg.persist_count);
      charge_in = det_next(charge_ff, chg_low, !chg_low, cfg.persist_count);
      booted_in = booted_ff;
      source_in = source_ff;
      if (mode) begin
         if (!booted_ff) begin
            if (vcap >= cfg.boot_voltage_mv) begin
               source_in = SrcCap;
               booted_in = 1'b1;
            end else begin
               source_in = SrcOff;
            end
         end
      end else begin
         source_in = SrcBat;
      end
   end

   // Restoring divider, one quotient bit per step.
   always_comb begin
      dividend = {10'd0, pwr} * 28'd1000;
      rem_sh   = {rem_ff[15:0], quo_ff[27]};
      rem_diff = rem_sh - {1'b0, vcap_ff};
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (cmd.load) begin
         rem_in = '0;
         quo_in = dividend;
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, vcap_ff}) begin
            rem_in = rem_diff;
            quo_in = {quo_ff[26:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[26:0], 1'b0};
         end
      end
   end

   // Current limits.
   always_comb begin
      q_sat = (vcap_ff == 16'd0) ? {14'd0, MaxCurrentMa} : quo_ff;
      if ((vcap_ff >= cfg.knee_voltage_mv) && (q_sat >= {14'd0, cfg.low_current_ma})) begin
         c1 = {14'd0, cfg.low_current_ma};
      end else begin
         c1 = q_sat;
      end
      c2     = (c1 >= {14'd0, MaxCurrentMa}) ? MaxCurrentMa : c1[13:0];
      cur_in = (level_ff.zone == ZoneHigh) ? 14'd0 : c2;
   end

   // DAC code: reciprocal estimate, then one correction step.
   always_comb begin
      q0      = prod1_ff[35:24];
      rem_dac = {cur_ff, 10'd0} - prod2_ff;
      dac     = (rem_dac >= {11'd0, DacDiv}) ? q0_ff + 12'd1 : q0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '{count: 8'd0, zone: ZoneMid};
         charge_ff <= '{count: 8'd0, zone: ZoneMid};
         booted_ff <= 1'b0;
         source_ff <= SrcOff;
      end else if (cmd.load) begin
         level_ff  <= level_in;
         charge_ff <= charge_in;
         booted_ff <= booted_in;
         source_ff <= source_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.load) begin
         vcap_ff <= vcap;
      end
      if (cmd.clamp) begin
         cur_ff <= cur_in;
      end
      if (cmd.dac_mul) begin
         prod1_ff <= 36'(cur_ff * DacRecip);
      end
      if (cmd.dac_fix) begin
         q0_ff    <= q0;
         prod2_ff <= 24'(q0 * DacDiv);
      end
      if (cmd.out_load) begin
         rsp_ff <= {1'b0, source_ff, (charge_ff.zone != ZoneLow), level_ff.zone,
                    cur_ff, dac};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

/* dv/testbench.sv */
// Checks the supercapacitor charge manager against an in-bench predictor of its
// control tick: supply source latch, the two persistence-filtered zone
// detectors, the power over voltage charge current with its limits, and the DAC
// code. A short directed part covers the register defaults and the corner cases.
// Several random phases follow, each with fresh register values. A final
// phase holds the result side off long enough for the block to stall its input.
module testbench;
   import scm_pkg::*;

   // The supply mode bit of a tick.
   localparam logic ModeBattery = 1'b0;
   localparam logic ModeCap     = 1'b1;

   // The index that no register answers to. Writes to it must change nothing.
   localparam logic [2:0] CsrUnused = 3'd7;

   // The DAC code is floor(mA * 4096 / 16500).
   localparam int unsigned DacFullScale = 4096;
   localparam int unsigned DacSpanMa    = 16500;

   // Even the slowest correct run, with every tick's work in the block and the
   // idle gaps drawn on either side, stays far below this limit.
   localparam int unsigned CycleLimit = 400000;

   // One control tick, laid out as req_tdata carries it.
   typedef struct packed {
      logic [4:0]  pad;
      logic        supply_mode;
      logic [17:0] power_mw;
      logic [15:0] input_mv;
      logic [15:0] cap_mv;
   } tick_type;

   // One tick result, laid out as rsp_tdata carries it.
   typedef struct packed {
      logic        pad;
      logic [1:0]  source;
      logic        boost;
      logic [1:0]  level;
      logic [13:0] current_ma;
      logic [11:0] dac;
   } charge_cmd_type;

   // A detector: its persistence count and its latched zone.
   typedef struct packed {
      logic [7:0] count;
      logic [1:0] zone;
   } zone_track_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   // [15:0] cap_voltage_mv, [31:16] input_voltage_mv, [49:32] charge_power_mw,
   // [50] supply_mode, [55:51] zero
   logic [ReqDataW-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   // [11:0] dac_code, [25:12] charge_current_ma, [27:26] cap_level,
   // [28] boost_enable, [30:29] source_select, [31] zero
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_valid;
   logic                csr_ready;
   logic [2:0]          csr_index;
   logic [15:0]         csr_data;

   // The predictor's copy of the registers and of the block's state.
   cfg_type        settings;
   zone_track_type level_trk;
   zone_track_type charge_trk;
   logic           booted;
   logic [1:0]     source_now;

   // Results that are predicted but not yet seen, oldest first.
   charge_cmd_type expected_cmds[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   // Pacing of both sides. An eager side never idles; hold_cycles asks the
   // receiver for one long hold-off, which it counts out in its own process.
   bit          req_eager = 1'b0;
   bit          rsp_eager = 1'b0;
   int unsigned hold_cycles = 0;

   supercap_charge_manager DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("%0t timeout after %0d cycles", $time, cycle_count);
         $display("testbench: done, errors");
         $finish;
      end
   end

   // One detector step. Below lo counts toward the low zone, at or above hi
   // toward the high zone, and anything between drops to mid at once. Both
   // zones share one count, and a persistence of zero latches on the first tick.
   function automatic zone_track_type next_zone(input zone_track_type trk, input int lo,
                                                input int hi, input int v);
      zone_track_type nxt;
      logic [1:0]     goal;
      nxt = trk;
      if (v < lo) begin
         goal = ZoneLow;
      end else if (v >= hi) begin
         goal = ZoneHigh;
      end else begin
         nxt.count = 8'd0;
         nxt.zone  = ZoneMid;
         return nxt;
      end
      nxt.count = trk.count + 8'd1;
      if (nxt.count >= settings.persist_count) begin
         nxt.count = 8'd0;
         nxt.zone  = goal;
      end
      return nxt;
   endfunction

   // Advances the predicted state by one accepted tick and returns its result.
   function automatic charge_cmd_type advance_tick(input tick_type t);
      charge_cmd_type cmd;
      int             thr;
      int unsigned    cur;
      // Battery mode always selects the battery. Capacitor mode switches over
      // only once the capacitor has reached the boot voltage. After that the
      // latch is set and capacitor mode keeps whatever source was last chosen.
      if (t.supply_mode == ModeCap) begin
         if (!booted) begin
            if (t.cap_mv >= settings.boot_voltage_mv) begin
               source_now = SrcCap;
               booted     = 1'b1;
            end else begin
               source_now = SrcOff;
            end
         end
      end else begin
         source_now = SrcBat;
      end

      level_trk = next_zone(level_trk, int'(settings.cap_low_mv),
                            int'(settings.cap_high_mv), int'(t.cap_mv));
      // The boost threshold is signed, so a drop larger than the input
      // voltage leaves the capacitor always above it.
      thr = int'(t.input_mv) - int'(settings.boost_drop_mv);
      charge_trk = next_zone(charge_trk, thr, thr, int'(t.cap_mv));

      // A full capacitor takes no current. A zero voltage saturates the
      // quotient, even at zero power, and the limits still apply after that.
      if (level_trk.zone == ZoneHigh) begin
         cur = 0;
      end else begin
         if (t.cap_mv == 16'd0)
            cur = MaxCurrentMa;
         else
            cur = (int'(t.power_mw) * 1000) / int'(t.cap_mv);
         if (t.cap_mv >= settings.knee_voltage_mv && cur >= settings.low_current_ma)
            cur = settings.low_current_ma;
         if (cur >= MaxCurrentMa)
            cur = MaxCurrentMa;
      end

      cmd.pad        = 1'b0;
      cmd.dac        = 12'((cur * DacFullScale) / DacSpanMa);
      cmd.current_ma = 14'(cur);
      cmd.level      = level_trk.zone;
      cmd.boost      = (charge_trk.zone != ZoneLow);
      cmd.source     = source_now;
      return cmd;
   endfunction

   function automatic tick_type make_tick(input logic [15:0] cap_mv,
                                          input logic [15:0] input_mv,
                                          input logic [17:0] power_mw, input logic mode);
      tick_type t;
      t.pad         = 5'd0;
      t.supply_mode = mode;
      t.power_mw    = power_mw;
      t.input_mv    = input_mv;
      t.cap_mv      = cap_mv;
      return t;
   endfunction

   // Offers one tick until the block takes it, then predicts its result.
   // With no idle gap drawn, valid stays high for the next tick. The
   // configuration valid is lowered here so that a run of register writes
   // never lowers and raises it in the same time step.
   task automatic send_tick(input tick_type t);
      int unsigned gap;
      csr_valid  <= 1'b0;
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      do @(posedge clock); while (!req_tready);
      expected_cmds.push_back(advance_tick(t));
      gap = req_eager ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Writes one register and mirrors it into the predictor. Only the bits of
   // each register's width count.
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CsrCapLow:    settings.cap_low_mv      = value;
         CsrCapHigh:   settings.cap_high_mv     = value;
         CsrBoostDrop: settings.boost_drop_mv   = value;
         CsrKnee:      settings.knee_voltage_mv = value;
         CsrLowCur:    settings.low_current_ma  = value[13:0];
         CsrPersist:   settings.persist_count   = value[7:0];
         CsrBoot:      settings.boot_voltage_mv = value;
         default: ;
      endcase
   endtask

   // Stops offering ticks and waits until every predicted result has come.
   // Every tick yields a result, so an empty queue means the block is idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Returns an extreme of the 16-bit range now and then, else the typical value.
   function automatic logic [15:0] extreme_or(input int unsigned typical);
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         default: return 16'(typical);
      endcase
   endfunction

   // Register defaults. The persistence of 50 keeps every zone mid here, so
   // these ticks exercise the boot latch, the zero-voltage saturation and
   // the knee and 10 A limits.
   task automatic test_reset_defaults();
      send_tick(make_tick(16'd0, 16'd0, 18'd0, ModeBattery));
      send_tick(make_tick(16'd0, 16'hFFFF, 18'h3FFFF, ModeCap));
      send_tick(make_tick(16'd14999, 16'd12000, 18'd1000, ModeCap));
      send_tick(make_tick(16'd15000, 16'd12000, 18'd1000, ModeCap));
      send_tick(make_tick(16'd100, 16'd5000, 18'd50, ModeCap));
      send_tick(make_tick(16'd19999, 16'd24000, 18'h3FFFF, ModeBattery));
      send_tick(make_tick(16'd20000, 16'd24000, 18'h3FFFF, ModeBattery));
      send_tick(make_tick(16'hFFFF, 16'hFFFF, 18'h3FFFF, ModeCap));
      send_tick(make_tick(16'd30000, 16'd24000, 18'd30000, ModeBattery));
   endtask

   // Zone latching and the corner cases of the registers.
   task automatic test_special_cases();
      drain();
      // Only the low byte of the persistence counts.
      write_reg(CsrPersist, 16'hAB01);
      write_reg(CsrCapLow, 16'd1000);
      write_reg(CsrCapHigh, 16'd2000);
      write_reg(CsrBoostDrop, 16'd0);
      write_reg(CsrKnee, 16'hFFFF);
      write_reg(CsrBoot, 16'd0);
      send_tick(make_tick(16'd999, 16'd1000, 18'd5000, ModeBattery));
      send_tick(make_tick(16'd1000, 16'd0, 18'd5000, ModeCap));
      send_tick(make_tick(16'd2000, 16'd0, 18'h3FFFF, ModeBattery));

      // With a persistence of zero, a zone latches on its first tick.
      drain();
      write_reg(CsrPersist, 16'hFF00);
      send_tick(make_tick(16'd500, 16'hFFFF, 18'd1, ModeBattery));

      // With the low threshold above the high one, the low test wins.
      drain();
      write_reg(CsrCapLow, 16'd5000);
      write_reg(CsrCapHigh, 16'd3000);
      send_tick(make_tick(16'd4000, 16'd0, 18'h3FFFF, ModeCap));
      send_tick(make_tick(16'd6000, 16'd0, 18'h3FFFF, ModeCap));

      // A low current limit above 10 A still ends at 10 A. A drop larger
      // than the input voltage makes the boost threshold negative.
      drain();
      write_reg(CsrCapLow, 16'd0);
      write_reg(CsrCapHigh, 16'hFFFF);
      write_reg(CsrKnee, 16'd0);
      write_reg(CsrLowCur, 16'hFFFF);
      write_reg(CsrBoostDrop, 16'hFFFF);
      send_tick(make_tick(16'd1000, 16'd0, 18'h3FFFF, ModeBattery));

      // A zero low current limit at the knee overrides the saturated current.
      drain();
      write_reg(CsrLowCur, 16'd0);
      send_tick(make_tick(16'd0, 16'hFFFF, 18'd0, ModeCap));

      // A write to the unused index is ignored.
      drain();
      write_reg(CsrUnused, 16'h1234);
      write_reg(CsrBoot, 16'hFFFF);
      send_tick(make_tick(16'hFFFF, 16'hFFFF, 18'h3FFFF, ModeCap));
   endtask

   // New random register values, then runs of ticks that stay in one zone long
   // enough for the detectors to latch, mixed with unrelated noise.
   task automatic test_random_phase(input int unsigned count);
      int unsigned sent;
      int unsigned run_len;
      int unsigned p;
      int unsigned vin_side;
      int unsigned lo;
      int unsigned hi;
      logic [1:0]  zone_pick;
      int          vcap;
      int          vin;
      drain();
      lo = $urandom_range(0, 30000);
      hi = lo + $urandom_range(1, 20000);
      case ($urandom_range(0, 5))
         0: lo = 0;
         1: hi = 65535;
         2: begin
            lo = 40000;
            hi = 20000;
         end
         3: begin
            lo = $urandom_range(0, 65535);
            hi = $urandom_range(0, 65535);
         end
         default: ;
      endcase
      write_reg(CsrCapLow, 16'(lo));
      write_reg(CsrCapHigh, 16'(hi));
      write_reg(CsrBoostDrop, extreme_or($urandom_range(0, 3000)));
      write_reg(CsrKnee, extreme_or($urandom_range(0, 65535)));
      write_reg(CsrLowCur, extreme_or($urandom_range(0, 12000)));
      case ($urandom_range(0, 7))
         0:       p = 0;
         1:       p = 255;
         default: p = $urandom_range(1, 4);
      endcase
      write_reg(CsrPersist, {8'($urandom), 8'(p)});
      write_reg(CsrBoot, extreme_or($urandom_range(0, 65535)));

      req_eager = ($urandom_range(0, 3) == 0);
      rsp_eager = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < count) begin
         zone_pick = 2'($urandom_range(0, 3));
         vin_side  = $urandom_range(0, 2);
         p         = (settings.persist_count > 4) ? 4 : settings.persist_count;
         run_len   = $urandom_range(1, 3 * p + 2);
         for (int k = 0; k < run_len && sent < count; k++) begin
            case (zone_pick)
               ZoneLow:
                  vcap = (settings.cap_low_mv == 16'd0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, settings.cap_low_mv - 1);
               ZoneHigh: vcap = $urandom_range(settings.cap_high_mv, 65535);
               ZoneMid:  vcap = $urandom_range(settings.cap_low_mv, settings.cap_high_mv);
               default:  vcap = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, 65535);
            endcase
            // Keep the capacitor on one side of the boost threshold for the
            // whole run, close to it, or pick the input voltage freely.
            case (vin_side)
               0: vin = vcap + int'(settings.boost_drop_mv) + 1 + int'($urandom_range(0, 40));
               1: vin = vcap + int'(settings.boost_drop_mv) - int'($urandom_range(0, 40));
               default: vin = $urandom_range(0, 65535);
            endcase
            if (vin < 0)
               vin = 0;
            else if (vin > 65535)
               vin = 65535;
            send_tick(make_tick(16'(vcap), 16'(vin),
                                $urandom_range(0, 1) ? 18'($urandom_range(0, 262143))
                                                     : 18'($urandom_range(0, 20000)),
                                1'($urandom_range(0, 1))));
            sent++;
         end
      end
   endtask

   // The receiver holds off for a long stretch while ticks keep coming
   // back to back, so the block fills up and must stall its input.
   task automatic test_backpressure();
      drain();
      req_eager   = 1'b1;
      rsp_eager   = 1'b0;
      hold_cycles = 300;
      repeat (30) begin
         send_tick(make_tick(16'($urandom), 16'($urandom), 18'($urandom), 1'($urandom)));
      end
      req_eager = 1'b0;
   endtask

   // Result side: an idle gap drawn per item, or one long hold-off on request.
   initial begin : receiver
      int unsigned stall;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = rsp_eager ? 0 : $urandom_range(0, 15);
         if (hold_cycles != 0) begin
            stall       = hold_cycles;
            hold_cycles = 0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Compares every accepted result, field by field, with the oldest prediction.
   always @(posedge clock) begin
      charge_cmd_type got;
      charge_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_cmds.size() == 0) begin
            $display("%0t unexpected result: expected none, got %h", $time, got);
            mismatch_count++;
         end else begin
            want = expected_cmds.pop_front();
            if (got.dac !== want.dac) begin
               $display("%0t dac_code: expected %0d, got %0d", $time, want.dac, got.dac);
               mismatch_count++;
            end
            if (got.current_ma !== want.current_ma) begin
               $display("%0t charge_current_ma: expected %0d, got %0d",
                        $time, want.current_ma, got.current_ma);
               mismatch_count++;
            end
            if (got.level !== want.level) begin
               $display("%0t cap_level: expected %0d, got %0d", $time, want.level, got.level);
               mismatch_count++;
            end
            if (got.boost !== want.boost) begin
               $display("%0t boost_enable: expected %0d, got %0d",
                        $time, want.boost, got.boost);
               mismatch_count++;
            end
            if (got.source !== want.source) begin
               $display("%0t source_select: expected %0d, got %0d",
                        $time, want.source, got.source);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;

      // Predicted state after reset: register defaults, both detectors mid,
      // the boot latch clear and every supply output off.
      settings.cap_low_mv      = 16'd12000;
      settings.cap_high_mv     = 16'd23000;
      settings.boost_drop_mv   = 16'd1000;
      settings.knee_voltage_mv = 16'd20000;
      settings.low_current_ma  = 14'd2000;
      settings.persist_count   = 8'd50;
      settings.boot_voltage_mv = 16'd15000;
      level_trk  = '{count: 8'd0, zone: ZoneMid};
      charge_trk = '{count: 8'd0, zone: ZoneMid};
      booted     = 1'b0;
      source_now = SrcOff;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_special_cases();
      repeat (7) test_random_phase(80);
      test_backpressure();

      // Let the last results come back, then give the block a little longer
      // so that any stray result would still be caught.
      drain();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

/* files.f */
hdl/scm_pkg.sv
hdl/scm_ctrl.sv
hdl/scm_dpath.sv
hdl/supercap_charge_manager.sv
dv/testbench.sv
